// ===== rtl/core/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
package spq_pkg;

  // action codes of an input beat
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // status codes of a result beat
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [7:0]  pri;
    logic [31:0] val;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t fresh;
  } ctl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// one slot of the sorted chain: compare against the new entry and shift
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctl_t  ctl,
  input  logic           occupied,
  input  logic           left_after,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  output logic           after,
  output spq_pkg::entry_t entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // new entry goes behind this slot when it holds an equal or lower priority
  assign after = occupied && (entry_r.pri <= ctl.fresh.pri);
  assign entry = entry_r;

  // keep, take the new entry, shift right on insert, shift left on remove
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins) begin
      if (!after) begin
        entry_nxt = left_after ? ctl.fresh : left_entry;
      end
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// sorted priority queue top level: chain of compare-and-shift cells
// the result strobe comes in the cycle after the accepting edge
// throughput: one insert or remove per cycle while busy is low; every cell compares and shifts in parallel
// reset: synchronous active-low rst_n empties the queue; busy is high during reset and
// until the first clock edge after rst_n rises, then stays low
// results cannot be stalled by the receiver
module sorted_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_action,
  input  logic [7:0]                   in_entry_priority,
  input  logic signed [31:0]           in_entry_value,
  output logic                         out_valid,
  output logic signed [31:0]           out_removed_value,
  output logic [1:0]                   out_status,
  output logic [$clog2(DEPTH + 1)-1:0] out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  logic [31:0]           out_removed_value_r;
  logic [31:0]           out_removed_value_nxt;
  spq_pkg::status_t      out_status_r;
  spq_pkg::status_t      out_status_nxt;
  logic [CNT_W-1:0]      out_occupancy_r;
  logic                  accept;
  logic                  full;
  logic                  empty;
  spq_pkg::ctl_t         ctl;
  logic [DEPTH-1:0]      after;
  spq_pkg::entry_t       entry [DEPTH];

  // input beat and queue condition
  assign accept = start && !busy_r;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  assign ctl.ins       = accept && (in_action == spq_pkg::ACT_INSERT) && !full;
  assign ctl.rem       = accept && (in_action == spq_pkg::ACT_REMOVE) && !empty;
  assign ctl.fresh.pri = in_entry_priority;
  assign ctl.fresh.val = in_entry_value;

  // the chain of cells
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_a;
      if (i == 0) begin : g_head
        assign left_e = ctl.fresh;
        assign left_a = 1'b1;
      end else begin : g_body
        assign left_e = entry[i-1];
        assign left_a = after[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign right_e = entry[i];
      end else begin : g_next
        assign right_e = entry[i+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .occupied    (CNT_W'(i) < count_r),
        .left_after  (left_a),
        .left_entry  (left_e),
        .right_entry (right_e),
        .after       (after[i]),
        .entry       (entry[i])
      );
    end
  endgenerate

  // count and result for this beat
  always_comb begin
    count_nxt             = count_r;
    out_removed_value_nxt = '0;
    if (in_action == spq_pkg::ACT_INSERT) begin
      out_status_nxt = full ? spq_pkg::ST_OVERFLOW : spq_pkg::ST_INSERTED;
      if (ctl.ins) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      out_status_nxt = empty ? spq_pkg::ST_UNDERFLOW : spq_pkg::ST_REMOVED;
      if (ctl.rem) begin
        count_nxt             = count_r - CNT_W'(1);
        out_removed_value_nxt = entry[0].val;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_removed_value_r <= out_removed_value_nxt;
      out_status_r        <= out_status_nxt;
      out_occupancy_r     <= count_nxt;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_value_r;
  assign out_status        = out_status_r;
  assign out_occupancy     = out_occupancy_r;

endmodule
